### hdl/sst_pkg.sv
// Package for the seek steering tick unit: fixed-point helpers, sequencer states
// and the control group of the shared divide/square-root unit. No dependencies.
package sst_pkg;

  localparam int unsigned CfgWidth   = 24;
  localparam int unsigned CfgIdxW    = 2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SPEED = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_FORCE = 2'd1;
  localparam logic [CfgWidth-1:0] MaxSpeedReset = 24'd6553600;
  localparam logic [CfgWidth-1:0] MaxForceReset = 24'd6554;
  localparam logic signed [31:0] SpeedYReset    = 32'sd983040;

  localparam int unsigned NumStates = 21;

  // Sequencer states, one-hot.
  typedef enum logic [NumStates-1:0] {
    ST_IDLE   = 21'd1 << 0,
    ST_ACC    = 21'd1 << 1,
    ST_VEL    = 21'd1 << 2,
    ST_SQX    = 21'd1 << 3,
    ST_SQY    = 21'd1 << 4,
    ST_SQS    = 21'd1 << 5,
    ST_CMP    = 21'd1 << 6,
    ST_SQRTGO = 21'd1 << 7,
    ST_SQRTW  = 21'd1 << 8,
    ST_MX     = 21'd1 << 9,
    ST_DXGO   = 21'd1 << 10,
    ST_DXW    = 21'd1 << 11,
    ST_MY     = 21'd1 << 12,
    ST_DYGO   = 21'd1 << 13,
    ST_DYW    = 21'd1 << 14,
    ST_VDONE  = 21'd1 << 15,
    ST_PX     = 21'd1 << 16,
    ST_PY     = 21'd1 << 17,
    ST_PDY    = 21'd1 << 18,
    ST_DIFF   = 21'd1 << 19,
    ST_OUT    = 21'd1 << 20
  } state_t;

  // Which vector the shared limit/rescale sequence is working on.
  typedef enum logic [1:0] {
    VM_SPEED = 2'd0,
    VM_DIR   = 2'd1,
    VM_FORCE = 2'd2
  } vec_mode_t;

  // Control group to the iterative divide/square-root unit.
  typedef struct packed {
    logic start;
    logic is_sqrt;
  } iter_ctrl_t;

  // Saturating signed 32-bit add and subtract.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) - 33'(b);
    if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return s[31:0];
  endfunction

  // Magnitude as unsigned; the most negative value maps to 2^31.
  function automatic logic [31:0] mag(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Apply the sign of r to a magnitude below 2^31.
  function automatic logic signed [31:0] with_sign(input logic signed [31:0] r,
                                                   input logic [31:0] m);
    return r[31] ? -$signed(m) : $signed(m);
  endfunction

endpackage

### hdl/sst_if.sv
// Handshake channels of the seek steering tick unit: tick input and state output.
// Depends on nothing.
interface sst_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic        [15:0] elapsed_time;
  logic signed [31:0] extra_force_x;
  logic signed [31:0] extra_force_y;
  modport source (output valid, target_x, target_y, elapsed_time, extra_force_x,
                  extra_force_y, input ready);
  modport sink (input valid, target_x, target_y, elapsed_time, extra_force_x,
                extra_force_y, output ready);
endinterface

interface sst_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

### hdl/seek_steering_tick_unit.sv
// One tick of a seek-steering vehicle in signed Q16.16: adds the external force,
// updates and limits the velocity, advances the location by velocity times
// elapsed time, and forms the next seek steer limited to max_force. The block
// takes no new item until the last one is handed to the output register. Each
// rescale uses the shared one-bit-per-cycle divide/square-root unit (32 steps
// per root, 24 per quotient) and a single 32x32 multiplier. A result that has
// not been taken yet adds its wait to the next item. Results wait in an output
// register while the next item is taken.
// Depends on sst_pkg, sst_if and sst_iter.
module seek_steering_tick_unit import sst_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgWidth-1:0] cfg_data,
  sst_in_if.sink              tick_in,
  sst_out_if.source           tick_out
);

  state_t             state;
  vec_mode_t          mode;
  logic [CfgWidth-1:0] max_speed;
  logic [CfgWidth-1:0] max_force;
  logic signed [31:0] ax, ay, vx, vy, lx, ly;
  logic signed [31:0] wx, wy;
  logic signed [31:0] tx, ty, fx, fy;
  logic [15:0]        et;
  logic [CfgWidth-1:0] lim;
  logic [63:0]        sq;
  logic [31:0]        len;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  iter_ctrl_t         ictrl;
  logic [63:0]        iopa;
  logic               idone;
  logic [31:0]        ires;

  assign tick_in.ready = (state == ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= MaxSpeedReset;
      max_force <= MaxForceReset;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MAX_SPEED) max_speed <= cfg_data;
      else if (cfg_index == CFG_MAX_FORCE) max_force <= cfg_data;
    end
  end

  // Shared multiplier operand selection and its product register.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_SQX:  begin mul_a = mag(wx); mul_b = mag(wx); end
      ST_SQY:  begin mul_a = mag(wy); mul_b = mag(wy); end
      ST_SQS:  begin mul_a = 32'(lim); mul_b = 32'(lim); end
      ST_MX:   begin mul_a = mag(wx); mul_b = 32'(lim); end
      ST_MY:   begin mul_a = mag(wy); mul_b = 32'(lim); end
      ST_PX:   begin mul_a = mag(vx); mul_b = 32'(et); end
      ST_PY:   begin mul_a = mag(vy); mul_b = 32'(et); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) prod <= mul_a * mul_b;

  // Requests to the divide/square-root unit.
  always_comb begin
    ictrl.start   = (state == ST_SQRTGO) || (state == ST_DXGO) || (state == ST_DYGO);
    ictrl.is_sqrt = (state == ST_SQRTGO);
    iopa          = (state == ST_SQRTGO) ? sq : prod;
  end

  sst_iter u_iter (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ictrl),
    .opa  (iopa),
    .opb  (len),
    .done (idone),
    .res  (ires)
  );

  // Sequencer and vehicle state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      mode           <= VM_SPEED;
      ax             <= '0;
      ay             <= '0;
      vx             <= '0;
      vy             <= SpeedYReset;
      lx             <= '0;
      ly             <= '0;
      tick_out.valid <= 1'b0;
    end else begin
      // A taken result clears the output register unless a new one replaces it.
      if (tick_out.valid && tick_out.ready && state != ST_OUT) tick_out.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (tick_in.valid) begin
            tx    <= tick_in.target_x;
            ty    <= tick_in.target_y;
            et    <= tick_in.elapsed_time;
            fx    <= tick_in.extra_force_x;
            fy    <= tick_in.extra_force_y;
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          ax    <= sat_add(ax, fx);
          ay    <= sat_add(ay, fy);
          state <= ST_VEL;
        end
        ST_VEL: begin
          wx    <= sat_add(vx, ax);
          wy    <= sat_add(vy, ay);
          lim   <= max_speed;
          mode  <= VM_SPEED;
          state <= ST_SQX;
        end
        ST_SQX: state <= ST_SQY;
        ST_SQY: begin
          sq    <= prod;
          state <= ST_SQS;
        end
        ST_SQS: begin
          sq    <= sq + prod;
          state <= ST_CMP;
        end
        ST_CMP: begin
          // The direction is always rescaled unless it is zero; limits only when over.
          if (mode == VM_DIR) begin
            if (sq == 64'd0) begin
              wx    <= '0;
              wy    <= '0;
              state <= ST_VDONE;
            end else begin
              state <= ST_SQRTGO;
            end
          end else if (sq > prod) begin
            state <= ST_SQRTGO;
          end else begin
            state <= ST_VDONE;
          end
        end
        ST_SQRTGO: state <= ST_SQRTW;
        ST_SQRTW: begin
          if (idone) begin
            len   <= ires;
            state <= ST_MX;
          end
        end
        ST_MX:   state <= ST_DXGO;
        ST_DXGO: state <= ST_DXW;
        ST_DXW: begin
          if (idone) begin
            wx    <= with_sign(wx, ires);
            state <= ST_MY;
          end
        end
        ST_MY:   state <= ST_DYGO;
        ST_DYGO: state <= ST_DYW;
        ST_DYW: begin
          if (idone) begin
            wy    <= with_sign(wy, ires);
            state <= ST_VDONE;
          end
        end
        ST_VDONE: begin
          unique case (mode)
            VM_SPEED: begin
              vx    <= wx;
              vy    <= wy;
              state <= ST_PX;
            end
            VM_DIR: begin
              wx    <= sat_sub(wx, vx);
              wy    <= sat_sub(wy, vy);
              lim   <= max_force;
              mode  <= VM_FORCE;
              state <= ST_SQX;
            end
            default: begin
              ax    <= wx;
              ay    <= wy;
              state <= ST_OUT;
            end
          endcase
        end
        ST_PX: state <= ST_PY;
        ST_PY: begin
          lx    <= sat_add(lx, with_sign(vx, prod[47:16]));
          state <= ST_PDY;
        end
        ST_PDY: begin
          ly    <= sat_add(ly, with_sign(vy, prod[47:16]));
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          wx    <= sat_sub(tx, lx);
          wy    <= sat_sub(ty, ly);
          lim   <= max_speed;
          mode  <= VM_DIR;
          state <= ST_SQX;
        end
        ST_OUT: begin
          // Hand the item over once the output register is free.
          if (!tick_out.valid || tick_out.ready) begin
            tick_out.valid <= 1'b1;
            tick_out.pos_x <= lx;
            tick_out.pos_y <= ly;
            tick_out.vel_x <= vx;
            tick_out.vel_y <= vy;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  property p_accept_leaves_idle;
    @(posedge clk) disable iff (rst) tick_in.valid && tick_in.ready |=> state == ST_ACC;
  endproperty
  a_accept_leaves_idle: assert property (p_accept_leaves_idle) else $error("accept lost");

  property p_done_when_waiting;
    @(posedge clk) disable iff (rst)
      idone |-> (state == ST_SQRTW) || (state == ST_DXW) || (state == ST_DYW);
  endproperty
  a_done_when_waiting: assert property (p_done_when_waiting) else $error("stray done");

  property p_out_from_seq;
    @(posedge clk) disable iff (rst) $rose(tick_out.valid) |-> $past(state == ST_OUT);
  endproperty
  a_out_from_seq: assert property (p_out_from_seq) else $error("stray result");

endmodule

### hdl/sst_iter.sv
// Shared iterative unit: restoring division (24 quotient bits) or integer
// square root (32 root bits), one bit per cycle. Depends on sst_pkg.
module sst_iter import sst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  iter_ctrl_t  ctrl,
  input  logic [63:0] opa,
  input  logic [31:0] opb,
  output logic        done,
  output logic [31:0] res
);

  logic        busy;
  logic        is_sqrt;
  logic [4:0]  count;
  logic [32:0] rem;
  logic [63:0] src;
  logic [31:0] divisor;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic [35:0] diff;
  logic        fits;

  // One shared compare-and-subtract step. The root remainder can reach twice
  // the root, so the remainder carries 33 bits.
  always_comb begin
    if (is_sqrt) begin
      rem_sh = {rem, src[63:62]};
      trial  = {1'b0, res, 2'b01};
    end else begin
      rem_sh = {1'b0, rem, src[63]};
      trial  = {3'b000, divisor};
    end
    diff = {1'b0, rem_sh} - {1'b0, trial};
    fits = !diff[35];
  end

  // Control: busy flag, step count and done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (busy && count == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: a quotient is below 2^24, so division starts 24 bits in.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      is_sqrt <= ctrl.is_sqrt;
      divisor <= opb;
      res     <= '0;
      if (ctrl.is_sqrt) begin
        rem   <= '0;
        src   <= opa;
        count <= 5'd31;
      end else begin
        rem   <= {1'b0, opa[55:24]};
        src   <= {opa[23:0], 40'd0};
        count <= 5'd23;
      end
    end else if (busy) begin
      rem   <= fits ? diff[32:0] : rem_sh[32:0];
      res   <= {res[30:0], fits};
      src   <= is_sqrt ? {src[61:0], 2'b00} : {src[62:0], 1'b0};
      count <= count - 5'd1;
    end
  end

  property p_no_start_busy;
    @(posedge clk) disable iff (rst) busy |-> !ctrl.start;
  endproperty
  a_no_start_busy: assert property (p_no_start_busy) else $error("start while busy");

  property p_done_ends;
    @(posedge clk) disable iff (rst) done |-> !busy;
  endproperty
  a_done_ends: assert property (p_done_ends) else $error("done while busy");

  property p_start_busy;
    @(posedge clk) disable iff (rst) ctrl.start |=> busy && !done;
  endproperty
  a_start_busy: assert property (p_start_busy) else $error("start did not take");

endmodule
